// ===== design/anp_pkg.sv =====
package anp_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X  = 8'h78;
    localparam logic [DIGIT_W-1:0] HEX_LETTER_BASE = 4'd10;

    // Character position saturates at two.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    // Commands passed from the classifier to the accumulator.
    typedef enum logic [1:0] {
        OP_DIGIT = 2'd0,
        OP_CLEAR = 2'd1,
        OP_END   = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic                 hex;
        logic [DIGIT_W-1:0]   digit;
        logic                 error;
    } t_op;

endpackage

// ===== design/ascii_number_parser.sv =====
// Output: a NUL terminator's command enters the command queue when its transfer is accepted,
// and the back end moves the finished result from the queue into the output register.
// Throughput: one character per cycle; the input stalls only when the two-entry
// command queue is full, which happens when the result register is not drained.
// Reset: i_rst_n is synchronous and active low; it empties the queue, clears the
// accumulator and the prefix/error tracking, and drops the output valid.
module ascii_number_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream: one ASCII character per transfer.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [anp_pkg::CHAR_W-1:0]          i_s_axis_tdata,  // [7:0] char_in
    // Output stream: one parsed number per terminated string.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [anp_pkg::VALUE_W-1:0]         o_m_axis_tdata,  // [63:0] value
    output logic                                o_m_axis_tuser   // [0] type_error
);

    // The front end classifies each character against the string state it keeps
    // (position, leading zero, hex prefix, latched error) and turns it into a
    // command: add a digit, clear for the hex prefix, or end the string. Invalid
    // characters and characters after an error produce no command at all.
    logic          w_accept;
    logic          w_push;
    anp_pkg::t_op  w_push_op;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;
    anp_pkg::t_op  w_q_op;

    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    anp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (i_s_axis_tdata),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    // A short queue decouples the classifier from the accumulator, so input
    // transfers keep flowing while a finished result waits on the output side.
    anp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_op    (w_q_op)
    );

    // The back end owns the 64-bit accumulator and the output register. Digit
    // commands retire every cycle; an end command waits only for the output
    // register to be free or being taken in the same cycle.
    anp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_q_valid),
        .i_op       (w_q_op),
        .o_op_pop   (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_value    (o_m_axis_tdata),
        .o_error    (o_m_axis_tuser)
    );

endmodule

// ===== design/anp_front.sv =====
module anp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [anp_pkg::CHAR_W-1:0]    i_char,
    output logic                          o_push,
    output anp_pkg::t_op                  o_op
);

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic       r_lead_zero;
    logic       n_lead_zero;
    logic       r_hex;
    logic       n_hex;
    logic       r_err;
    logic       n_err;

    logic                           w_is_dec;
    logic                           w_is_upper;
    logic                           w_is_lower;
    logic                           w_is_x;
    logic                           w_valid_digit;
    logic [anp_pkg::DIGIT_W-1:0]    w_digit;
    logic [anp_pkg::CHAR_W-1:0]     w_off;

    assign w_is_dec   = (i_char >= anp_pkg::CHAR_ZERO) && (i_char <= anp_pkg::CHAR_NINE);
    assign w_is_upper = (i_char >= anp_pkg::CHAR_UPPER_A) && (i_char <= anp_pkg::CHAR_UPPER_F);
    assign w_is_lower = (i_char >= anp_pkg::CHAR_LOWER_A) && (i_char <= anp_pkg::CHAR_LOWER_F);
    assign w_is_x     = (i_char == anp_pkg::CHAR_LOWER_X) || (i_char == anp_pkg::CHAR_UPPER_X);
    assign w_valid_digit = w_is_dec || (r_hex && (w_is_upper || w_is_lower));

    always_comb begin
        priority if (w_is_dec) begin
            w_off   = i_char - anp_pkg::CHAR_ZERO;
            w_digit = w_off[anp_pkg::DIGIT_W-1:0];
        end else if (w_is_upper) begin
            w_off   = i_char - anp_pkg::CHAR_UPPER_A;
            w_digit = w_off[anp_pkg::DIGIT_W-1:0] + anp_pkg::HEX_LETTER_BASE;
        end else begin
            w_off   = i_char - anp_pkg::CHAR_LOWER_A;
            w_digit = w_off[anp_pkg::DIGIT_W-1:0] + anp_pkg::HEX_LETTER_BASE;
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_lead_zero = r_lead_zero;
        n_hex       = r_hex;
        n_err       = r_err;
        o_push      = 1'b0;
        o_op.kind   = anp_pkg::OP_DIGIT;
        o_op.hex    = r_hex;
        o_op.digit  = w_digit;
        o_op.error  = r_err;
        if (i_accept) begin
            if (i_char == anp_pkg::CHAR_NUL) begin
                // End of string: report and start over.
                o_push      = 1'b1;
                o_op.kind   = anp_pkg::OP_END;
                n_pos       = anp_pkg::POS_FIRST;
                n_lead_zero = 1'b0;
                n_hex       = 1'b0;
                n_err       = 1'b0;
            end else begin
                if (!r_err) begin
                    if (r_pos == anp_pkg::POS_SECOND && r_lead_zero && w_is_x) begin
                        n_hex     = 1'b1;
                        o_push    = 1'b1;
                        o_op.kind = anp_pkg::OP_CLEAR;
                    end else if (!w_valid_digit) begin
                        n_err = 1'b1;
                    end else begin
                        o_push = 1'b1;
                        if (r_pos == anp_pkg::POS_FIRST && i_char == anp_pkg::CHAR_ZERO) begin
                            n_lead_zero = 1'b1;
                        end
                    end
                end
                if (r_pos != anp_pkg::POS_LATER) begin
                    n_pos = r_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= anp_pkg::POS_FIRST;
            r_lead_zero <= 1'b0;
            r_hex       <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_lead_zero <= n_lead_zero;
            r_hex       <= n_hex;
            r_err       <= n_err;
        end
    end

endmodule

// ===== design/anp_fifo.sv =====
module anp_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  anp_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output anp_pkg::t_op o_op
);

    anp_pkg::t_op r_mem [anp_pkg::FIFO_DEPTH];

    logic [anp_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [anp_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [anp_pkg::FIFO_CNT_W-1:0] r_count;
    logic                           w_do_push;
    logic                           w_do_pop;

    assign o_full    = (r_count == anp_pkg::FIFO_CNT_W'(anp_pkg::FIFO_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_op      = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == anp_pkg::FIFO_PTR_W'(anp_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_wr_ptr + anp_pkg::FIFO_PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == anp_pkg::FIFO_PTR_W'(anp_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_rd_ptr + anp_pkg::FIFO_PTR_W'(1);
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + anp_pkg::FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - anp_pkg::FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/anp_back.sv =====
module anp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_op_valid,
    input  anp_pkg::t_op                  i_op,
    output logic                          o_op_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [anp_pkg::VALUE_W-1:0]   o_value,
    output logic                          o_error
);

    logic [anp_pkg::VALUE_W-1:0] r_acc;
    logic [anp_pkg::VALUE_W-1:0] n_acc;
    logic                        r_valid;
    logic [anp_pkg::VALUE_W-1:0] r_value;
    logic                        r_error;
    logic                        w_out_free;
    logic                        w_emit;
    logic [anp_pkg::VALUE_W-1:0] w_digit_ext;

    assign w_out_free  = !r_valid || i_ready;
    assign o_op_pop    = i_op_valid && ((i_op.kind != anp_pkg::OP_END) || w_out_free);
    assign w_emit      = o_op_pop && (i_op.kind == anp_pkg::OP_END);
    assign w_digit_ext = anp_pkg::VALUE_W'(i_op.digit);

    // acc*16 is a shift; acc*10 is acc*8 + acc*2.
    always_comb begin
        n_acc = r_acc;
        if (o_op_pop) begin
            unique case (i_op.kind)
                anp_pkg::OP_DIGIT: begin
                    if (i_op.hex) begin
                        n_acc = {r_acc[anp_pkg::VALUE_W-5:0], 4'b0000} + w_digit_ext;
                    end else begin
                        n_acc = {r_acc[anp_pkg::VALUE_W-4:0], 3'b000}
                              + {r_acc[anp_pkg::VALUE_W-2:0], 1'b0} + w_digit_ext;
                    end
                end
                anp_pkg::OP_CLEAR: n_acc = '0;
                anp_pkg::OP_END:   n_acc = '0;
                default:           n_acc = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_value <= i_op.error ? '0 : r_acc;
            r_error <= i_op.error;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_error = r_error;

endmodule

// ===== tb/ascii_number_parser_tb.sv =====
// One parsed number as it leaves the block: the value and the invalid-character flag.
typedef struct packed {
    logic [anp_pkg::VALUE_W-1:0] value;
    logic                        type_error;
} parsed_number_t;

// Tracks the parse of the current string and keeps the numbers still owed by the block.
class parser_scoreboard;
    parsed_number_t             owed_q[$];
    logic [anp_pkg::VALUE_W-1:0] acc;
    logic [1:0]                 char_pos;
    bit                         lead_zero;
    bit                         hex_mode;
    bit                         bad_seen;
    int                         mismatches;
    int                         checked;
    int                         flagged;

    function new();
        restart();
    endfunction

    function void restart();
        acc       = '0;
        char_pos  = anp_pkg::POS_FIRST;
        lead_zero = 1'b0;
        hex_mode  = 1'b0;
        bad_seen  = 1'b0;
    endfunction

    // Digit weight of a character in the current base, or -1 when it is not a digit.
    function int digit_of(logic [7:0] c);
        if (c >= anp_pkg::CHAR_ZERO && c <= anp_pkg::CHAR_NINE)
            return int'(c - anp_pkg::CHAR_ZERO);
        if (hex_mode && c >= anp_pkg::CHAR_UPPER_A && c <= anp_pkg::CHAR_UPPER_F)
            return int'(c - anp_pkg::CHAR_UPPER_A) + 10;
        if (hex_mode && c >= anp_pkg::CHAR_LOWER_A && c <= anp_pkg::CHAR_LOWER_F)
            return int'(c - anp_pkg::CHAR_LOWER_A) + 10;
        return -1;
    endfunction

    // Called once per accepted input transfer.
    function void note_char(logic [7:0] c);
        parsed_number_t num;
        int             d;
        if (c == anp_pkg::CHAR_NUL) begin
            num.value      = bad_seen ? '0 : acc;
            num.type_error = bad_seen;
            owed_q.push_back(num);
            restart();
            return;
        end
        if (!bad_seen) begin
            if (char_pos == anp_pkg::POS_SECOND && lead_zero &&
                (c == anp_pkg::CHAR_LOWER_X || c == anp_pkg::CHAR_UPPER_X)) begin
                hex_mode = 1'b1;
                acc      = '0;
            end else begin
                d = digit_of(c);
                if (d < 0) begin
                    bad_seen = 1'b1;
                end else begin
                    acc = acc * (hex_mode ? 64'd16 : 64'd10) + 64'(d);
                    if (char_pos == anp_pkg::POS_FIRST && c == anp_pkg::CHAR_ZERO)
                        lead_zero = 1'b1;
                end
            end
        end
        if (char_pos != anp_pkg::POS_LATER)
            char_pos = char_pos + 2'd1;
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // Called once per accepted output transfer.
    function void check_number(logic [anp_pkg::VALUE_W-1:0] value, logic type_error);
        parsed_number_t num;
        if (owed_q.size() == 0) begin
            report($sformatf("result with nothing owed: value %h type_error %b",
                             value, type_error));
            return;
        end
        num = owed_q.pop_front();
        checked++;
        if (num.type_error)
            flagged++;
        if (value !== num.value)
            report($sformatf("value: expected %h, got %h", num.value, value));
        if (type_error !== num.type_error)
            report($sformatf("type_error: expected %b, got %b", num.type_error, type_error));
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Anything still owed at the end of the run is a failure.
    function void close_out();
        if (owed_q.size() != 0)
            report($sformatf("%0d numbers never came out", owed_q.size()));
    endfunction
endclass

module ascii_number_parser_tb;
    import anp_pkg::*;

    localparam int RANDOM_CHARS = 930;
    localparam int CYCLE_LIMIT  = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [CHAR_W-1:0]   i_s_axis_tdata = '0;   // [7:0] char_in
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]  o_m_axis_tdata;        // [63:0] value
    logic                o_m_axis_tuser;        // [0] type_error

    parser_scoreboard    sb = new();
    logic [CHAR_W-1:0]   text_q[$];
    int                  src_idle_pct  = 0;
    int                  sink_idle_pct = 0;
    int                  random_chars  = 0;
    int                  strings_sent  = 0;
    int                  cycle_count   = 0;

    ascii_number_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random; with a zero percentage it is always ready.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Output monitor. Reading right after the edge sees the values from before it,
    // so a transfer is counted exactly when the block counted it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_number(o_m_axis_tdata, o_m_axis_tuser);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d numbers owed",
                     cycle_count, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // Drives one character and returns at the edge where its transfer is accepted.
    // The sender may idle first; tvalid gets one assignment per edge at most.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_char(c);
    endtask

    // Sends the characters in text_q followed by the NUL terminator.
    task automatic send_text();
        foreach (text_q[k])
            send_char(text_q[k]);
        send_char(CHAR_NUL);
        strings_sent++;
    endtask

    function automatic void load_text(string s);
        text_q.delete();
        for (int k = 0; k < s.len(); k++)
            text_q.push_back(s[k]);
    endfunction

    // Holds the input quiet until every owed number has come out.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [CHAR_W-1:0] random_hex_digit();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10)
            return CHAR_ZERO + CHAR_W'(d);
        if ($urandom_range(0, 1) == 1)
            return CHAR_UPPER_A + CHAR_W'(d - 10);
        return CHAR_LOWER_A + CHAR_W'(d - 10);
    endfunction

    // Mostly well-formed decimal or hex strings with random digits, some long enough to
    // wrap the 64-bit value; a share carry one bad character, and a few are pure noise.
    function automatic void build_random_text();
        int shape;
        int len;
        int spot;
        text_q.delete();
        shape = $urandom_range(0, 99);
        if (shape < 90) begin
            if ($urandom_range(0, 1) == 0) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
                repeat (len)
                    text_q.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            end else begin
                text_q.push_back(CHAR_ZERO);
                text_q.push_back(($urandom_range(0, 1) == 1) ? CHAR_UPPER_X : CHAR_LOWER_X);
                if ($urandom_range(0, 19) == 0) begin
                    // All-ones value, the top of the unsigned range.
                    repeat (16)
                        text_q.push_back(($urandom_range(0, 1) == 1) ? CHAR_UPPER_F
                                                                     : CHAR_LOWER_F);
                end else begin
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                      : $urandom_range(0, 8);
                    repeat (len)
                        text_q.push_back(random_hex_digit());
                end
            end
            if (shape >= 70 && text_q.size() > 0) begin
                spot = $urandom_range(0, text_q.size() - 1);
                if ($urandom_range(0, 1) == 1)
                    text_q[spot] = ($urandom_range(0, 1) == 1) ? CHAR_UPPER_X : CHAR_LOWER_X;
                else
                    text_q[spot] = CHAR_W'($urandom_range(1, 255));
            end
        end else begin
            len = $urandom_range(1, 6);
            repeat (len)
                text_q.push_back(CHAR_W'($urandom_range(1, 255)));
        end
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: empty, bare prefix, mixed-case hex, an 'x' after a second
        // leading zero, an 'x' after a nonzero digit, a high byte followed by a digit
        // that must be ignored, and a prefix mark repeated inside a hex string.
        load_text("");
        send_text();
        load_text("0x");
        send_text();
        load_text("0XfA");
        send_text();
        load_text("00x");
        send_text();
        load_text("1x");
        send_text();
        text_q.delete();
        text_q.push_back(8'hFF);
        text_q.push_back(CHAR_ZERO + 8'd5);
        send_text();
        load_text("0x0X");
        send_text();

        // Random part in three idling phases; the input drains before each one.
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    src_idle_pct  = 35;
                    sink_idle_pct = 59;
                end
                1: begin
                    src_idle_pct  = 59;
                    sink_idle_pct = 35;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            while (random_chars < (phase + 1) * RANDOM_CHARS / 3) begin
                build_random_text();
                random_chars += text_q.size() + 1;
                send_text();
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        sb.close_out();
        $display("Sent %0d strings (%0d random characters); %0d numbers checked, %0d of them",
                 strings_sent, random_chars, sb.checked, sb.flagged);
        $display("flagged for an invalid character, under three idling patterns.");
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
